// ===== src/mjd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mjd_pkg
// Shared types, codes and helpers of the multicore job dispatcher.
// ----------------------------------------------------------------------------
package mjd_pkg;

    localparam int MAX_CORES = 8;

    localparam logic [2:0] SCH_FCFS = 3'd0;
    localparam logic [2:0] SCH_SJF  = 3'd1;
    localparam logic [2:0] SCH_PSJF = 3'd2;
    localparam logic [2:0] SCH_PRI  = 3'd3;
    localparam logic [2:0] SCH_PPRI = 3'd4;
    localparam logic [2:0] SCH_RR   = 3'd5;

    localparam logic [1:0] KIND_ARRIVE = 2'd0;
    localparam logic [1:0] KIND_FINISH = 2'd1;
    localparam logic [1:0] KIND_EXPIRE = 2'd2;

    localparam logic CFG_SCHEME = 1'b0;
    localparam logic CFG_CORES  = 1'b1;

    typedef struct packed {
        logic [15:0] num;
        logic [31:0] arrival;
        logic [23:0] remaining;
        logic [15:0] urgency;
        logic [31:0] waited;
        logic        resp_valid;
        logic [31:0] resp;
        logic [31:0] last;
        logic [31:0] started;
    } job_rec_t;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic [2:0] scheme;
    } q_cmd_t;

    typedef struct packed {
        logic done;
        logic empty;
        logic room;
    } q_stat_t;

    function automatic logic [23:0] key_of(job_rec_t r, logic [2:0] s);
        logic [23:0] k;
        case (s) inside
            SCH_SJF, SCH_PSJF: k = r.remaining;
            SCH_PRI, SCH_PPRI: k = {8'd0, r.urgency};
            default:           k = 24'd0;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

// ===== src/mjd_core_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mjd_core_ram
// Per-core job record memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mjd_core_ram #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire mjd_pkg::job_rec_t wdata,
    input  wire logic [AW-1:0]    raddr,
    output mjd_pkg::job_rec_t     rdata
);
    import mjd_pkg::*;

    job_rec_t mem [DEPTH];
    job_rec_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== src/mjd_ready_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mjd_ready_queue
// Ordered ready queue held in a circular memory: sorted insertion by scan
// and shift, removal from the head.
// ----------------------------------------------------------------------------
module mjd_ready_queue #(
    parameter int QUEUE_DEPTH = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mjd_pkg::q_cmd_t   cmd,
    input  wire mjd_pkg::job_rec_t push_rec,
    output mjd_pkg::q_stat_t       stat,
    output mjd_pkg::job_rec_t      pop_rec
);
    import mjd_pkg::*;

    localparam int SLOTS = QUEUE_DEPTH + 1;
    localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNTW  = $clog2(SLOTS + 1);

    typedef enum logic [7:0] {
        Q_IDLE     = 8'b0000_0001,
        Q_SCAN_RD  = 8'b0000_0010,
        Q_SCAN_CMP = 8'b0000_0100,
        Q_SHIFT_RD = 8'b0000_1000,
        Q_SHIFT_WR = 8'b0001_0000,
        Q_PUT      = 8'b0010_0000,
        Q_POP_RD   = 8'b0100_0000,
        Q_POP_DONE = 8'b1000_0000
    } q_state_t;

    q_state_t        state_reg, state_next;
    logic [AW-1:0]   head_reg, head_next;
    logic [CNTW-1:0] count_reg, count_next;
    logic [CNTW-1:0] pos_reg, pos_next;
    logic [CNTW-1:0] q_reg, q_next;
    job_rec_t        new_reg, new_next;
    logic [2:0]      sch_reg, sch_next;

    job_rec_t        mem [SLOTS];
    job_rec_t        rd_data_reg;
    logic            we;
    logic [AW-1:0]   waddr;
    logic [AW-1:0]   raddr;
    job_rec_t        wdata;

    function automatic logic [AW-1:0] phys(input logic [AW-1:0] h,
                                           input logic [CNTW-1:0] p);
        logic [CNTW:0] s;
        s = (CNTW+1)'(h) + (CNTW+1)'(p);
        if (s >= (CNTW+1)'(SLOTS))
        begin
            s = s - (CNTW+1)'(SLOTS);
        end
        return AW'(s);
    endfunction

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        q_next     = q_reg;
        new_next   = new_reg;
        sch_next   = sch_reg;
        we         = 1'b0;
        waddr      = phys(head_reg, pos_reg);
        wdata      = new_reg;
        raddr      = phys(head_reg, pos_reg);
        unique case (state_reg)
            Q_IDLE:
            begin
                if (cmd.push)
                begin
                    new_next = push_rec;
                    sch_next = cmd.scheme;
                    pos_next = '0;
                    state_next = (count_reg == '0) ? Q_PUT : Q_SCAN_RD;
                end
                else if (cmd.pop)
                begin
                    state_next = Q_POP_RD;
                end
            end
            Q_SCAN_RD:
            begin
                state_next = Q_SCAN_CMP;
            end
            Q_SCAN_CMP:
            begin
                if (key_of(rd_data_reg, sch_reg) <= key_of(new_reg, sch_reg))
                begin
                    pos_next = pos_reg + 1'b1;
                    state_next = (pos_reg + 1'b1 == count_reg) ? Q_PUT : Q_SCAN_RD;
                end
                else
                begin
                    q_next = count_reg;
                    state_next = Q_SHIFT_RD;
                end
            end
            Q_SHIFT_RD:
            begin
                raddr = phys(head_reg, q_reg - 1'b1);
                state_next = Q_SHIFT_WR;
            end
            Q_SHIFT_WR:
            begin
                we    = 1'b1;
                waddr = phys(head_reg, q_reg);
                wdata = rd_data_reg;
                q_next = q_reg - 1'b1;
                state_next = (q_reg - 1'b1 == pos_reg) ? Q_PUT : Q_SHIFT_RD;
            end
            Q_PUT:
            begin
                we = 1'b1;
                count_next = count_reg + 1'b1;
                state_next = Q_IDLE;
            end
            Q_POP_RD:
            begin
                raddr = head_reg;
                state_next = Q_POP_DONE;
            end
            Q_POP_DONE:
            begin
                head_next  = phys(head_reg, CNTW'(1));
                count_next = count_reg - 1'b1;
                state_next = Q_IDLE;
            end
            default:
            begin
                state_next = Q_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
        pos_reg <= pos_next;
        q_reg   <= q_next;
        new_reg <= new_next;
        sch_reg <= sch_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= Q_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    assign stat.done  = (state_reg == Q_PUT) || (state_reg == Q_POP_DONE);
    assign stat.empty = (count_reg == '0);
    assign stat.room  = (count_reg < CNTW'(QUEUE_DEPTH));
    assign pop_rec    = rd_data_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNTW'(SLOTS))
        else $error("ready queue count beyond its slots");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == Q_IDLE && cmd.pop && !cmd.push) |-> count_reg != '0)
        else $error("pop requested on an empty ready queue");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == Q_IDLE && cmd.push) |-> count_reg < CNTW'(SLOTS))
        else $error("push requested with no free slot");

endmodule
`default_nettype wire

// ===== src/mjd_stats.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mjd_stats
// Saturating sums of wait, turnaround and response, and the finished count.
// ----------------------------------------------------------------------------
module mjd_stats (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              fin_valid,
    input  wire mjd_pkg::job_rec_t fin_rec,
    input  wire logic [31:0]       fin_time,
    output logic [47:0]            wait_sum,
    output logic [47:0]            turnaround_sum,
    output logic [47:0]            response_sum,
    output logic [31:0]            finished_count
);
    import mjd_pkg::*;

    logic [47:0] wait_reg, wait_next;
    logic [47:0] turn_reg, turn_next;
    logic [47:0] resp_reg, resp_next;
    logic [31:0] done_reg, done_next;
    logic [31:0] turn_delta;

    function automatic logic [47:0] add_sat(input logic [47:0] a, input logic [31:0] b);
        logic [48:0] s;
        s = {1'b0, a} + 49'(b);
        return s[48] ? 48'hFFFF_FFFF_FFFF : s[47:0];
    endfunction

    always_comb
    begin
        turn_delta = fin_time - fin_rec.arrival;
        wait_next = wait_reg;
        turn_next = turn_reg;
        resp_next = resp_reg;
        done_next = done_reg;
        if (fin_valid)
        begin
            wait_next = add_sat(wait_reg, fin_rec.waited);
            turn_next = add_sat(turn_reg, turn_delta);
            if (fin_rec.resp_valid)
            begin
                resp_next = add_sat(resp_reg, fin_rec.resp);
            end
            if (done_reg != 32'hFFFF_FFFF)
            begin
                done_next = done_reg + 32'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_reg <= '0;
            turn_reg <= '0;
            resp_reg <= '0;
            done_reg <= '0;
        end
        else
        begin
            wait_reg <= wait_next;
            turn_reg <= turn_next;
            resp_reg <= resp_next;
            done_reg <= done_next;
        end
    end

    assign wait_sum       = wait_reg;
    assign turnaround_sum = turn_reg;
    assign response_sum   = resp_reg;
    assign finished_count = done_reg;

endmodule
`default_nettype wire

// ===== src/multicore_job_dispatcher_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multicore_job_dispatcher_unit
// Job dispatcher over up to MAX_CORES cores with an ordered ready queue.
//
//   Channel   Handshake            Carries
//   event     event_valid/stall    kind, job_id, now, run_length,
//                                  job_priority, core
//   result    result_valid/stall   assigned, core_index, dispatched_job,
//                                  queue_full, total_* sums, jobs_done
//   cfg       cfg_valid/ready      cfg_index, cfg_data
//
// An arrival placed on a core takes the sweep over the cores in use, a
// decision and the output load. A queued arrival also hands the job to
// the ready queue, which scans entries and shifts those from the insertion
// point on. A finish takes the sweep plus a pop; an expiry skips the sweep,
// reads its core and may requeue before the pop. The single read port of
// each memory makes the sweep, the scan and the shift go one entry at a time.
// Reset idles all cores, empties the queue and clears the sums.
// A result held by result_stall lets the next event in, but that event's result then waits in S_OUT.
// ----------------------------------------------------------------------------
module multicore_job_dispatcher_unit #(
    parameter int QUEUE_DEPTH = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        event_valid,
    output logic             event_stall,
    input  wire logic [1:0]  kind,
    input  wire logic [15:0] job_id,
    input  wire logic [31:0] now,
    input  wire logic [23:0] run_length,
    input  wire logic [15:0] job_priority,
    input  wire logic [2:0]  core,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic             assigned,
    output logic [2:0]       core_index,
    output logic [15:0]      dispatched_job,
    output logic             queue_full,
    output logic [47:0]      total_wait,
    output logic [47:0]      total_turnaround,
    output logic [47:0]      total_response,
    output logic [31:0]      jobs_done,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [3:0]  cfg_data
);
    import mjd_pkg::*;

    localparam int CW = (MAX_CORES > 1) ? $clog2(MAX_CORES) : 1;
    localparam int NW = $clog2(MAX_CORES + 1);

    typedef enum logic [9:0] {
        S_IDLE      = 10'b00_0000_0001,
        S_SWEEP     = 10'b00_0000_0010,
        S_DECIDE    = 10'b00_0000_0100,
        S_EXP_RD    = 10'b00_0000_1000,
        S_EXP_CHK   = 10'b00_0001_0000,
        S_PUSH_REQ  = 10'b00_0010_0000,
        S_PUSH_WAIT = 10'b00_0100_0000,
        S_POP       = 10'b00_1000_0000,
        S_POP_WAIT  = 10'b01_0000_0000,
        S_OUT       = 10'b10_0000_0000
    } state_t;

    state_t          state_reg, state_next;
    logic [2:0]      scheme_reg;
    logic [3:0]      core_count_reg;
    logic [MAX_CORES-1:0] busy_reg, busy_next;

    logic [1:0]      kind_reg, kind_next;
    logic [15:0]     id_reg, id_next;
    logic [31:0]     now_reg, now_next;
    logic [23:0]     rt_reg, rt_next;
    logic [15:0]     pri_reg, pri_next;
    logic [2:0]      core_reg, core_next;
    logic [NW-1:0]   n_reg, n_next;
    logic [2:0]      s_reg, s_next;

    logic [NW-1:0]   sw_idx_reg, sw_idx_next;
    logic            rd_v_reg, rd_v_next;
    logic [CW-1:0]   rd_idx_reg, rd_idx_next;
    logic            have_reg, have_next;
    logic [CW-1:0]   pick_reg, pick_next;
    job_rec_t        best_reg, best_next;
    job_rec_t        fin_reg, fin_next;
    job_rec_t        ins_reg, ins_next;
    logic            cont_pop_reg, cont_pop_next;

    logic            res_assigned_reg, res_assigned_next;
    logic [2:0]      res_core_reg, res_core_next;
    logic [15:0]     res_disp_reg, res_disp_next;
    logic            res_full_reg, res_full_next;

    logic            out_valid_reg, out_valid_next;
    logic            out_assigned_reg;
    logic [2:0]      out_core_reg;
    logic [15:0]     out_disp_reg;
    logic            out_full_reg;
    logic [47:0]     out_wait_reg, out_turn_reg, out_resp_reg;
    logic [31:0]     out_done_reg;
    logic            out_load;

    logic [4:0]      cc_ext, n5;
    logic [NW-1:0]   n_live;
    logic [2:0]      s_live;
    logic            ev_accept;

    logic            ram_we;
    logic [CW-1:0]   ram_waddr, ram_raddr;
    job_rec_t        ram_wdata, ram_rdata;

    q_cmd_t          q_cmd;
    q_stat_t         q_stat;
    job_rec_t        q_pop_rec;

    logic            fin_valid;
    job_rec_t        fin_rec;
    logic [47:0]     sum_wait, sum_turn, sum_resp;
    logic [31:0]     sum_done;

    job_rec_t        new_rec, placed_rec, adv_rec, cur_rec;
    logic [31:0]     el;
    logic            idle_found;
    logic [CW-1:0]   idle_idx;
    logic [CW-1:0]   c_idx;
    logic            sweep_issue;

    function automatic logic loses(job_rec_t a, job_rec_t b, logic [2:0] s);
        logic [23:0] ka;
        logic [23:0] kb;
        logic        r;
        ka = 24'd0;
        kb = 24'd0;
        r  = 1'b0;
        if (s == SCH_PSJF || s == SCH_PPRI)
        begin
            if (s == SCH_PSJF)
            begin
                ka = a.remaining;
                kb = b.remaining;
            end
            else
            begin
                ka = {8'd0, a.urgency};
                kb = {8'd0, b.urgency};
            end
            r = (ka != kb) ? (ka > kb) : (a.arrival > b.arrival);
        end
        return r;
    endfunction

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scheme_reg     <= SCH_FCFS;
            core_count_reg <= 4'd1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SCHEME: scheme_reg     <= cfg_data[2:0];
                CFG_CORES:  core_count_reg <= cfg_data;
                default:    scheme_reg     <= scheme_reg;
            endcase
        end
    end

    always_comb
    begin
        cc_ext = {1'b0, core_count_reg};
        if (cc_ext == 5'd0)
        begin
            n5 = 5'd1;
        end
        else if (cc_ext > 5'(MAX_CORES))
        begin
            n5 = 5'(MAX_CORES);
        end
        else
        begin
            n5 = cc_ext;
        end
        n_live = NW'(n5);
        s_live = (scheme_reg > SCH_RR) ? SCH_FCFS : scheme_reg;
    end

    assign event_stall = (state_reg != S_IDLE);
    assign ev_accept   = event_valid && !event_stall;
    assign c_idx       = CW'(core_reg);

    always_comb
    begin
        new_rec            = '0;
        new_rec.num        = id_reg;
        new_rec.arrival    = now_reg;
        new_rec.remaining  = rt_reg;
        new_rec.urgency    = pri_reg;
        new_rec.last       = now_reg;
        placed_rec         = new_rec;
        placed_rec.resp_valid = 1'b1;
        placed_rec.started = now_reg;

        cur_rec = ram_rdata;
        el      = now_reg - cur_rec.last;
        adv_rec = cur_rec;
        adv_rec.remaining = (el >= {8'd0, cur_rec.remaining}) ? 24'd0
                                                             : cur_rec.remaining - el[23:0];
        adv_rec.last = now_reg;

        idle_found = 1'b0;
        idle_idx   = '0;
        for (int i = MAX_CORES - 1; i >= 0; i--)
        begin
            if (!busy_reg[i] && (NW'(i) < n_reg))
            begin
                idle_found = 1'b1;
                idle_idx   = CW'(i);
            end
        end
        sweep_issue = (sw_idx_reg < n_reg);
    end

    always_comb
    begin
        state_next        = state_reg;
        busy_next         = busy_reg;
        kind_next         = kind_reg;
        id_next           = id_reg;
        now_next          = now_reg;
        rt_next           = rt_reg;
        pri_next          = pri_reg;
        core_next         = core_reg;
        n_next            = n_reg;
        s_next            = s_reg;
        sw_idx_next       = sw_idx_reg;
        rd_v_next         = 1'b0;
        rd_idx_next       = rd_idx_reg;
        have_next         = have_reg;
        pick_next         = pick_reg;
        best_next         = best_reg;
        fin_next          = fin_reg;
        ins_next          = ins_reg;
        cont_pop_next     = cont_pop_reg;
        res_assigned_next = res_assigned_reg;
        res_core_next     = res_core_reg;
        res_disp_next     = res_disp_reg;
        res_full_next     = res_full_reg;
        out_valid_next    = out_valid_reg;
        out_load          = 1'b0;
        ram_we            = 1'b0;
        ram_waddr         = rd_idx_reg;
        ram_wdata         = adv_rec;
        ram_raddr         = c_idx;
        q_cmd.push        = 1'b0;
        q_cmd.pop         = 1'b0;
        q_cmd.scheme      = s_reg;
        fin_valid         = 1'b0;
        fin_rec           = fin_reg;

        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (ev_accept)
                begin
                    kind_next = kind;
                    id_next   = job_id;
                    now_next  = now;
                    rt_next   = run_length;
                    pri_next  = job_priority;
                    core_next = core;
                    n_next    = n_live;
                    s_next    = s_live;
                    sw_idx_next = '0;
                    have_next = 1'b0;
                    res_assigned_next = 1'b0;
                    res_disp_next     = 16'd0;
                    res_full_next     = 1'b0;
                    res_core_next     = (kind == KIND_FINISH || kind == KIND_EXPIRE) ?
                                        core : 3'd0;
                    if (kind == KIND_ARRIVE)
                    begin
                        state_next = S_SWEEP;
                    end
                    else if (kind == KIND_FINISH && 5'(core) < 5'(n_live))
                    begin
                        state_next = S_SWEEP;
                    end
                    else if (kind == KIND_EXPIRE && 5'(core) < 5'(n_live))
                    begin
                        state_next = S_EXP_RD;
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_SWEEP:
            begin
                ram_raddr = CW'(sw_idx_reg);
                if (sweep_issue)
                begin
                    sw_idx_next = sw_idx_reg + 1'b1;
                    rd_v_next   = 1'b1;
                    rd_idx_next = CW'(sw_idx_reg);
                end
                if (rd_v_reg && busy_reg[rd_idx_reg])
                begin
                    ram_we = 1'b1;
                    if (loses(adv_rec, new_rec, s_reg) &&
                        (!have_reg || loses(adv_rec, best_reg, s_reg)))
                    begin
                        have_next = 1'b1;
                        pick_next = rd_idx_reg;
                        best_next = adv_rec;
                    end
                    if (rd_idx_reg == c_idx)
                    begin
                        fin_next = adv_rec;
                    end
                end
                if (!sweep_issue && !rd_v_reg)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (kind_reg == KIND_ARRIVE)
                begin
                    if (idle_found)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = idle_idx;
                        ram_wdata = placed_rec;
                        busy_next[idle_idx] = 1'b1;
                        res_assigned_next = 1'b1;
                        res_core_next = 3'(idle_idx);
                        state_next = S_OUT;
                    end
                    else if ((s_reg == SCH_PSJF || s_reg == SCH_PPRI) &&
                             q_stat.room && have_reg)
                    begin
                        ins_next = best_reg;
                        if (best_reg.resp_valid && best_reg.started == now_reg)
                        begin
                            ins_next.resp_valid = 1'b0;
                            ins_next.resp       = 32'd0;
                            ins_next.started    = 32'd0;
                        end
                        ram_we    = 1'b1;
                        ram_waddr = pick_reg;
                        ram_wdata = placed_rec;
                        res_assigned_next = 1'b1;
                        res_core_next = 3'(pick_reg);
                        cont_pop_next = 1'b0;
                        state_next = S_PUSH_REQ;
                    end
                    else if (q_stat.room)
                    begin
                        ins_next = new_rec;
                        cont_pop_next = 1'b0;
                        state_next = S_PUSH_REQ;
                    end
                    else
                    begin
                        res_full_next = 1'b1;
                        state_next = S_OUT;
                    end
                end
                else
                begin
                    if (busy_reg[c_idx])
                    begin
                        fin_valid = 1'b1;
                        fin_rec   = fin_reg;
                    end
                    state_next = S_POP;
                end
            end
            S_EXP_RD:
            begin
                ram_raddr  = c_idx;
                state_next = S_EXP_CHK;
            end
            S_EXP_CHK:
            begin
                if (busy_reg[c_idx])
                begin
                    if (el >= {8'd0, cur_rec.remaining})
                    begin
                        fin_valid  = 1'b1;
                        fin_rec    = cur_rec;
                        state_next = S_POP;
                    end
                    else
                    begin
                        ins_next = adv_rec;
                        cont_pop_next = 1'b1;
                        state_next = S_PUSH_REQ;
                    end
                end
                else
                begin
                    state_next = S_POP;
                end
            end
            S_PUSH_REQ:
            begin
                q_cmd.push = 1'b1;
                state_next = S_PUSH_WAIT;
            end
            S_PUSH_WAIT:
            begin
                if (q_stat.done)
                begin
                    state_next = cont_pop_reg ? S_POP : S_OUT;
                end
            end
            S_POP:
            begin
                busy_next[c_idx] = 1'b0;
                if (q_stat.empty)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    q_cmd.pop  = 1'b1;
                    state_next = S_POP_WAIT;
                end
            end
            S_POP_WAIT:
            begin
                if (q_stat.done)
                begin
                    ram_wdata = q_pop_rec;
                    ram_wdata.waited = ((q_pop_rec.waited + (now_reg - q_pop_rec.last))
                                        < q_pop_rec.waited) ? 32'hFFFF_FFFF :
                                       q_pop_rec.waited + (now_reg - q_pop_rec.last);
                    if (!q_pop_rec.resp_valid)
                    begin
                        ram_wdata.resp_valid = 1'b1;
                        ram_wdata.resp       = now_reg - q_pop_rec.arrival;
                        ram_wdata.started    = now_reg;
                    end
                    ram_wdata.last = now_reg;
                    ram_we    = 1'b1;
                    ram_waddr = c_idx;
                    busy_next[c_idx]  = 1'b1;
                    res_assigned_next = 1'b1;
                    res_disp_next     = q_pop_rec.num;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            busy_reg      <= '0;
            rd_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            busy_reg      <= busy_next;
            rd_v_reg      <= rd_v_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg         <= kind_next;
        id_reg           <= id_next;
        now_reg          <= now_next;
        rt_reg           <= rt_next;
        pri_reg          <= pri_next;
        core_reg         <= core_next;
        n_reg            <= n_next;
        s_reg            <= s_next;
        sw_idx_reg       <= sw_idx_next;
        rd_idx_reg       <= rd_idx_next;
        have_reg         <= have_next;
        pick_reg         <= pick_next;
        best_reg         <= best_next;
        fin_reg          <= fin_next;
        ins_reg          <= ins_next;
        cont_pop_reg     <= cont_pop_next;
        res_assigned_reg <= res_assigned_next;
        res_core_reg     <= res_core_next;
        res_disp_reg     <= res_disp_next;
        res_full_reg     <= res_full_next;
        if (out_load)
        begin
            out_assigned_reg <= res_assigned_reg;
            out_core_reg     <= res_core_reg;
            out_disp_reg     <= res_disp_reg;
            out_full_reg     <= res_full_reg;
            out_wait_reg     <= sum_wait;
            out_turn_reg     <= sum_turn;
            out_resp_reg     <= sum_resp;
            out_done_reg     <= sum_done;
        end
    end

    mjd_core_ram #(
        .DEPTH (MAX_CORES),
        .AW    (CW)
    ) u_core_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mjd_ready_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ready_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (q_cmd),
        .push_rec (ins_reg),
        .stat     (q_stat),
        .pop_rec  (q_pop_rec)
    );

    mjd_stats u_stats (
        .clk            (clk),
        .rst_n          (rst_n),
        .fin_valid      (fin_valid),
        .fin_rec        (fin_rec),
        .fin_time       (now_reg),
        .wait_sum       (sum_wait),
        .turnaround_sum (sum_turn),
        .response_sum   (sum_resp),
        .finished_count (sum_done)
    );

    assign result_valid     = out_valid_reg;
    assign assigned         = out_assigned_reg;
    assign core_index       = out_core_reg;
    assign dispatched_job   = out_disp_reg;
    assign queue_full       = out_full_reg;
    assign total_wait       = out_wait_reg;
    assign total_turnaround = out_turn_reg;
    assign total_response   = out_resp_reg;
    assign jobs_done        = out_done_reg;

endmodule
`default_nettype wire
